/* rtl/bmrp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bmrp_pkg
// Types, constants and command codes for the Barrett reduce / power block.
// ----------------------------------------------------------------------------
package bmrp_pkg;

    localparam int WORD_W    = 64;
    localparam int HALF_W    = WORD_W / 2;
    localparam int MOD_W     = 31;
    localparam int QUO_W     = 63;
    localparam int EXP_W     = 63;
    localparam int EXP_BITS  = 63;
    localparam int DIV_CNT_W = $clog2(WORD_W);

    localparam logic [MOD_W-1:0]  MOD_MIN      = MOD_W'(2);
    localparam logic [WORD_W-1:0] RECIP_RESET  = {1'b1, {(WORD_W-1){1'b0}}};

    // multiplier operand pairs
    localparam logic [2:0] MUL_LL = 3'd0;
    localparam logic [2:0] MUL_HL = 3'd1;
    localparam logic [2:0] MUL_LH = 3'd2;
    localparam logic [2:0] MUL_HH = 3'd3;
    localparam logic [2:0] MUL_QM = 3'd4;
    localparam logic [2:0] MUL_SQ = 3'd5;
    localparam logic [2:0] MUL_RB = 3'd6;

    // accumulator ops
    localparam logic [1:0] ACC_HOLD  = 2'd0;
    localparam logic [1:0] ACC_LOAD  = 2'd1;
    localparam logic [1:0] ACC_ADD32 = 2'd2;
    localparam logic [1:0] ACC_ADD64 = 2'd3;

    // where a finished reduction goes
    localparam logic [1:0] DEST_OUT  = 2'd0;
    localparam logic [1:0] DEST_BASE = 2'd1;
    localparam logic [1:0] DEST_RES  = 2'd2;

    typedef struct packed {
        logic             op;
        logic [WORD_W-1:0] operand;
        logic [EXP_W-1:0]  exponent;
    } bmrp_req_t;

    typedef struct packed {
        logic [QUO_W-1:0] quotient;
        logic [MOD_W-1:0] remainder;
    } bmrp_rsp_t;

    typedef struct packed {
        logic       load;
        logic [2:0] mul_sel;
        logic [1:0] acc_op;
        logic       n_from_prod;
        logic       fin;
        logic [1:0] dest;
        logic       exp_shift;
        logic       out_pow;
        logic       div_step;
        logic       recip_inc;
    } bmrp_cmd_t;

    typedef struct packed {
        logic op;
        logic exp_zero;
        logic exp_bit0;
        logic exp_last;
    } bmrp_status_t;

endpackage
`default_nettype wire

/* rtl/bmrp_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bmrp_dp
// Datapath: shared 32x32 multiplier, 128-bit accumulator, Barrett correction,
// power operands and the bit-serial reciprocal divider.
// ----------------------------------------------------------------------------
module bmrp_dp
    import bmrp_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire bmrp_req_t       req,
    input  wire logic            cfg_we,
    input  wire logic [MOD_W-1:0] cfg_wdata,
    input  wire bmrp_cmd_t       cmd,
    output bmrp_status_t         status,
    output logic                 done,
    output bmrp_rsp_t            rsp
);

    logic                  op_reg;
    logic [WORD_W-1:0]     n_reg;
    logic [EXP_BITS-1:0]   exp_reg;
    logic [HALF_W-1:0]     base_reg;
    logic [HALF_W-1:0]     res_reg;
    logic [WORD_W-1:0]     prod_reg;
    logic [2*WORD_W-1:0]   acc_reg;
    logic [2*WORD_W-1:0]   acc_next;
    logic [MOD_W-1:0]      mod_reg;
    logic [MOD_W-1:0]      mod_next;
    logic [WORD_W-1:0]     recip_reg;
    logic [WORD_W-1:0]     recip_next;
    logic [MOD_W-1:0]      div_rem_reg;
    logic [MOD_W-1:0]      div_rem_next;
    logic [QUO_W-1:0]      quo_out_reg;
    logic [MOD_W-1:0]      rem_out_reg;
    logic                  done_reg;

    logic [HALF_W-1:0]     mul_a;
    logic [HALF_W-1:0]     mul_b;
    logic [HALF_W-1:0]     mod_ext;
    logic [WORD_W-1:0]     x_est;
    logic [HALF_W-1:0]     r_est;
    logic                  wrap;
    logic [WORD_W-1:0]     quo_fix;
    logic [HALF_W-1:0]     rem_fix;
    logic [MOD_W:0]        div_trial;
    logic [MOD_W:0]        div_sub;
    logic                  div_ge;

    assign mod_ext = HALF_W'(mod_reg);

    always_comb
    begin
        case (cmd.mul_sel)
            MUL_LL:
            begin
                mul_a = n_reg[HALF_W-1:0];
                mul_b = recip_reg[HALF_W-1:0];
            end
            MUL_HL:
            begin
                mul_a = n_reg[WORD_W-1:HALF_W];
                mul_b = recip_reg[HALF_W-1:0];
            end
            MUL_LH:
            begin
                mul_a = n_reg[HALF_W-1:0];
                mul_b = recip_reg[WORD_W-1:HALF_W];
            end
            MUL_HH:
            begin
                mul_a = n_reg[WORD_W-1:HALF_W];
                mul_b = recip_reg[WORD_W-1:HALF_W];
            end
            MUL_QM:
            begin
                mul_a = acc_reg[WORD_W+HALF_W-1:WORD_W];
                mul_b = mod_ext;
            end
            MUL_SQ:
            begin
                mul_a = base_reg;
                mul_b = base_reg;
            end
            MUL_RB:
            begin
                mul_a = res_reg;
                mul_b = base_reg;
            end
            default:
            begin
                mul_a = n_reg[HALF_W-1:0];
                mul_b = recip_reg[HALF_W-1:0];
            end
        endcase
    end

    always_comb
    begin
        case (cmd.acc_op)
            ACC_LOAD:  acc_next = {{WORD_W{1'b0}}, prod_reg};
            ACC_ADD32: acc_next = acc_reg + {{HALF_W{1'b0}}, prod_reg, {HALF_W{1'b0}}};
            ACC_ADD64: acc_next = acc_reg + {prod_reg, {WORD_W{1'b0}}};
            default:   acc_next = acc_reg;
        endcase
    end

    // Barrett correction: estimate is exact or one too high
    assign x_est   = acc_reg[2*WORD_W-1:WORD_W];
    assign r_est   = n_reg[HALF_W-1:0] - prod_reg[HALF_W-1:0];
    assign wrap    = (r_est >= mod_ext);
    assign quo_fix = wrap ? (x_est - WORD_W'(1)) : x_est;
    assign rem_fix = wrap ? (r_est + mod_ext) : r_est;

    // reciprocal: restoring division of all-ones by the modulus
    assign div_trial    = {div_rem_reg, 1'b1};
    assign div_sub      = div_trial - {1'b0, mod_reg};
    assign div_ge       = (div_trial >= {1'b0, mod_reg});
    assign div_rem_next = div_ge ? div_sub[MOD_W-1:0] : div_trial[MOD_W-1:0];

    assign mod_next = (cfg_wdata < MOD_MIN) ? MOD_MIN : cfg_wdata;

    always_comb
    begin
        recip_next = recip_reg;
        if (cmd.div_step)
        begin
            recip_next = {recip_reg[WORD_W-2:0], div_ge};
        end
        else if (cmd.recip_inc)
        begin
            recip_next = recip_reg + WORD_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mod_reg   <= MOD_MIN;
            recip_reg <= RECIP_RESET;
            done_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                mod_reg <= mod_next;
            end
            recip_reg <= recip_next;
            done_reg  <= (cmd.fin && (cmd.dest == DEST_OUT)) || cmd.out_pow;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= WORD_W'(mul_a) * WORD_W'(mul_b);
        acc_reg  <= acc_next;

        if (cfg_we)
        begin
            div_rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            div_rem_reg <= div_rem_next;
        end

        if (cmd.load)
        begin
            op_reg  <= req.op;
            n_reg   <= req.operand;
            exp_reg <= req.exponent[EXP_BITS-1:0];
            res_reg <= HALF_W'(1);
        end
        else
        begin
            if (cmd.n_from_prod)
            begin
                n_reg <= prod_reg;
            end
            if (cmd.exp_shift)
            begin
                exp_reg <= exp_reg >> 1;
            end
            if (cmd.fin && (cmd.dest == DEST_BASE))
            begin
                base_reg <= rem_fix;
            end
            if (cmd.fin && (cmd.dest == DEST_RES))
            begin
                res_reg <= rem_fix;
            end
        end

        if (cmd.fin && (cmd.dest == DEST_OUT))
        begin
            quo_out_reg <= quo_fix[QUO_W-1:0];
            rem_out_reg <= rem_fix[MOD_W-1:0];
        end
        else if (cmd.out_pow)
        begin
            quo_out_reg <= '0;
            rem_out_reg <= res_reg[MOD_W-1:0];
        end
    end

    assign status.op       = op_reg;
    assign status.exp_zero = (exp_reg == '0);
    assign status.exp_bit0 = exp_reg[0];
    assign status.exp_last = ((exp_reg >> 1) == '0);

    assign done          = done_reg;
    assign rsp.quotient  = quo_out_reg;
    assign rsp.remainder = rem_out_reg;

endmodule
`default_nettype wire

/* rtl/bmrp_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bmrp_ctrl
// Sequencer: reduction micro-steps, square-and-multiply loop and reciprocal
// recompute after a modulus write.
// ----------------------------------------------------------------------------
module bmrp_ctrl
    import bmrp_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic         cfg_we,
    input  wire bmrp_status_t status,
    output bmrp_cmd_t         cmd,
    output logic              busy
);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_DISP  = 5'd1;
    localparam logic [4:0] S_R0    = 5'd2;
    localparam logic [4:0] S_R1    = 5'd3;
    localparam logic [4:0] S_R2    = 5'd4;
    localparam logic [4:0] S_R3    = 5'd5;
    localparam logic [4:0] S_R4    = 5'd6;
    localparam logic [4:0] S_R5    = 5'd7;
    localparam logic [4:0] S_R6    = 5'd8;
    localparam logic [4:0] S_BIT   = 5'd9;
    localparam logic [4:0] S_NEXT  = 5'd10;
    localparam logic [4:0] S_MULRB = 5'd11;
    localparam logic [4:0] S_MULSQ = 5'd12;
    localparam logic [4:0] S_LOADN = 5'd13;
    localparam logic [4:0] S_DIV   = 5'd14;
    localparam logic [4:0] S_DINC  = 5'd15;

    logic [4:0]           state_reg;
    logic [4:0]           state_next;
    logic [1:0]           dest_reg;
    logic [1:0]           dest_next;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_CNT_W-1:0] cnt_next;

    always_comb
    begin
        state_next = state_reg;
        dest_next  = dest_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.mul_sel = MUL_LL;
        cmd.acc_op  = ACC_HOLD;
        cmd.dest    = dest_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                if (!status.op)
                begin
                    dest_next  = DEST_OUT;
                    state_next = S_R0;
                end
                else if (status.exp_zero)
                begin
                    cmd.out_pow = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    dest_next  = DEST_BASE;
                    state_next = S_R0;
                end
            end
            S_R0:
            begin
                cmd.mul_sel = MUL_LL;
                state_next  = S_R1;
            end
            S_R1:
            begin
                cmd.acc_op  = ACC_LOAD;
                cmd.mul_sel = MUL_HL;
                state_next  = S_R2;
            end
            S_R2:
            begin
                cmd.acc_op  = ACC_ADD32;
                cmd.mul_sel = MUL_LH;
                state_next  = S_R3;
            end
            S_R3:
            begin
                cmd.acc_op  = ACC_ADD32;
                cmd.mul_sel = MUL_HH;
                state_next  = S_R4;
            end
            S_R4:
            begin
                cmd.acc_op = ACC_ADD64;
                state_next = S_R5;
            end
            S_R5:
            begin
                cmd.mul_sel = MUL_QM;
                state_next  = S_R6;
            end
            S_R6:
            begin
                cmd.fin = 1'b1;
                case (dest_reg)
                    DEST_OUT:  state_next = S_IDLE;
                    DEST_BASE: state_next = S_BIT;
                    DEST_RES:  state_next = S_NEXT;
                    default:   state_next = S_IDLE;
                endcase
            end
            S_BIT:
            begin
                if (status.exp_bit0)
                begin
                    dest_next  = DEST_RES;
                    state_next = S_MULRB;
                end
                else
                begin
                    state_next = S_NEXT;
                end
            end
            S_NEXT:
            begin
                cmd.exp_shift = 1'b1;
                if (status.exp_last)
                begin
                    cmd.out_pow = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    dest_next  = DEST_BASE;
                    state_next = S_MULSQ;
                end
            end
            S_MULRB:
            begin
                cmd.mul_sel = MUL_RB;
                state_next  = S_LOADN;
            end
            S_MULSQ:
            begin
                cmd.mul_sel = MUL_SQ;
                state_next  = S_LOADN;
            end
            S_LOADN:
            begin
                cmd.n_from_prod = 1'b1;
                state_next      = S_R0;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(WORD_W - 1))
                begin
                    state_next = S_DINC;
                end
            end
            S_DINC:
            begin
                cmd.recip_inc = 1'b1;
                state_next    = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // a modulus write restarts the reciprocal
        if (cfg_we)
        begin
            cmd.div_step  = 1'b0;
            cmd.recip_inc = 1'b0;
            cnt_next      = '0;
            state_next    = S_DIV;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            dest_reg  <= DEST_OUT;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            dest_reg  <= dest_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule
`default_nettype wire

/* rtl/barrett_modular_reduce_and_power.sv */
`default_nettype none
// Op 0 gives quotient and remainder, done pulsing with them; one item at a time.
// Op 1 runs square-and-multiply, the base and each product taken through a Barrett reduction
//   on the one shared 32x32 multiplier; a zero exponent finishes with no reduction.
//   The next start is taken in the cycle done is high.
// A modulus write holds busy while the reciprocal is divided out bit by bit.
// Reset: modulus 2, reciprocal 2^63, no clearing pass; results cannot be stalled.
// ----------------------------------------------------------------------------
// barrett_modular_reduce_and_power
// Barrett quotient/remainder and square-and-multiply modular power.
// ----------------------------------------------------------------------------
module barrett_modular_reduce_and_power
    import bmrp_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire bmrp_req_t        req,
    output logic                  done,
    output bmrp_rsp_t             rsp,
    input  wire logic             cfg_we,
    input  wire logic [MOD_W-1:0] cfg_wdata
);

    bmrp_cmd_t    cmd;
    bmrp_status_t status;

    bmrp_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cfg_we (cfg_we),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    bmrp_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .status    (status),
        .done      (done),
        .rsp       (rsp)
    );

endmodule
`default_nettype wire
